// ===== rtl/core/ics_pkg.sv =====
// shared constants, widths and payload types for the icosphere subdivider
package ics_pkg;

    localparam int FRAC_BITS = 14;

    localparam int C_W   = 16;              // coordinate width
    localparam int S_W   = C_W + 1;         // sum of two corners
    localparam int SQ_W  = 2 * S_W - 1;     // square of a sum, unsigned
    localparam int L2_W  = 2 * S_W;         // sum of three squares
    localparam int RT_W  = L2_W / 2;        // integer square root width
    localparam int RM_W  = RT_W + 3;        // square root remainder
    localparam int Q_W   = FRAC_BITS + 1;   // quotient bits, quotient <= 2^FRAC_BITS
    localparam int D_W   = RT_W + 1;        // divisor 2*len
    localparam int NUM_W = D_W + Q_W;       // dividend 2*|s|*2^FRAC_BITS + len

    localparam int unsigned MAG_LIM = (FRAC_BITS < 15) ? (32'd1 << FRAC_BITS) : 32'd32767;

    // sums, squares, length sum, root steps, divider setup, divide steps, result
    localparam int LAT = 3 + RT_W + 1 + Q_W + 1;

    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_CTR    = 2'd3;

    typedef logic [2:0][C_W-1:0] t_vec;     // index 0 x, 1 y, 2 z

    typedef struct packed {
        logic signed [C_W-1:0] first_x;
        logic signed [C_W-1:0] first_y;
        logic signed [C_W-1:0] first_z;
        logic signed [C_W-1:0] second_x;
        logic signed [C_W-1:0] second_y;
        logic signed [C_W-1:0] second_z;
        logic signed [C_W-1:0] third_x;
        logic signed [C_W-1:0] third_y;
        logic signed [C_W-1:0] third_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [C_W-1:0] out_a_x;
        logic signed [C_W-1:0] out_a_y;
        logic signed [C_W-1:0] out_a_z;
        logic signed [C_W-1:0] out_b_x;
        logic signed [C_W-1:0] out_b_y;
        logic signed [C_W-1:0] out_b_z;
        logic signed [C_W-1:0] out_c_x;
        logic signed [C_W-1:0] out_c_y;
        logic signed [C_W-1:0] out_c_z;
        logic        [1:0]     sub_slot;
        logic                  is_last;
    } t_tri_out;

endpackage

// ===== rtl/core/ics_if.sv =====
// valid/ready channels for input triangles and child triangles
interface ics_in_if import ics_pkg::*;;
    logic    valid;
    logic    ready;
    t_tri_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ics_out_if import ics_pkg::*;;
    logic     valid;
    logic     ready;
    t_tri_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/icosphere_triangle_subdivider.sv =====
// icosphere subdivider top: three midpoint lanes in a stalling pipeline, then the child sender
// the first child becomes valid once the triangle has passed through every lane stage into the sender;
// the sender puts out the four children of a triangle in turn and takes the next one as the last child is accepted;
// the lanes themselves take one triangle per cycle and stall as a whole when the sender is full
// reset: synchronous active-low i_rst_n clears the stage valid bits and the sender, no clearing pass
module icosphere_triangle_subdivider import ics_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ics_in_if.sink    i_tri,
    ics_out_if.source o_tri
);

    logic [LAT-1:0] r_vld;
    t_tri_in        r_cor [LAT];
    logic           w_adv;
    logic           w_take;
    t_vec           w_p0, w_p1, w_p2;
    t_vec           w_ab, w_bc, w_ca;
    t_vec           w_v0, w_v1, w_v2;

    assign w_adv       = !r_vld[LAT-1] || w_take;
    assign i_tri.ready = w_adv;

    assign w_p0 = {i_tri.data.first_z, i_tri.data.first_y, i_tri.data.first_x};
    assign w_p1 = {i_tri.data.second_z, i_tri.data.second_y, i_tri.data.second_x};
    assign w_p2 = {i_tri.data.third_z, i_tri.data.third_y, i_tri.data.third_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_tri.valid};
        end
    end

    // corners ride alongside the lanes so they pass through untouched
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cor[0] <= i_tri.data;
            for (int k = 1; k < LAT; k++) begin
                r_cor[k] <= r_cor[k-1];
            end
        end
    end

    ics_lane u_lane_ab (.i_clk(i_clk), .i_adv(w_adv), .i_p(w_p0), .i_q(w_p1), .o_m(w_ab));
    ics_lane u_lane_bc (.i_clk(i_clk), .i_adv(w_adv), .i_p(w_p1), .i_q(w_p2), .o_m(w_bc));
    ics_lane u_lane_ca (.i_clk(i_clk), .i_adv(w_adv), .i_p(w_p2), .i_q(w_p0), .o_m(w_ca));

    assign w_v0 = {r_cor[LAT-1].first_z, r_cor[LAT-1].first_y, r_cor[LAT-1].first_x};
    assign w_v1 = {r_cor[LAT-1].second_z, r_cor[LAT-1].second_y, r_cor[LAT-1].second_x};
    assign w_v2 = {r_cor[LAT-1].third_z, r_cor[LAT-1].third_y, r_cor[LAT-1].third_x};

    ics_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[LAT-1]),
        .i_v0    (w_v0),
        .i_v1    (w_v1),
        .i_v2    (w_v2),
        .i_ab    (w_ab),
        .i_bc    (w_bc),
        .i_ca    (w_ca),
        .o_take  (w_take),
        .o_tri   (o_tri)
    );

endmodule

// ===== rtl/core/ics_lane.sv =====
// one midpoint lane: sum, squared length, pipelined root, pipelined divide
module ics_lane import ics_pkg::*; (
    input  logic i_clk,
    input  logic i_adv,
    input  t_vec i_p,
    input  t_vec i_q,
    output t_vec o_m
);

    logic signed [S_W-1:0]  r_s1 [3];
    logic signed [S_W-1:0]  r_s2 [3];
    logic        [SQ_W-1:0] r_sq [3];
    logic signed [2*S_W-1:0] w_sq [3];

    logic [RM_W-1:0]       r_rm [RT_W+1];
    logic [RT_W-1:0]       r_rt [RT_W+1];
    logic [L2_W-1:0]       r_l2 [RT_W+1];
    logic signed [S_W-1:0] r_sv [RT_W+1][3];

    logic [D_W-1:0] r_dr [Q_W+1][3];
    logic [Q_W-1:0] r_dq [Q_W+1][3];
    logic [D_W-1:0] r_dn [Q_W+1];
    logic           r_sg [Q_W+1][3];
    logic           r_zr [Q_W+1];

    t_vec r_m;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sq[a] = r_s1[a] * r_s1[a];
        end
    end

    // front: corner sums, squares, squared length
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_s1[a] <= S_W'($signed(i_p[a])) + S_W'($signed(i_q[a]));
                r_sq[a] <= w_sq[a][SQ_W-1:0];
                r_s2[a] <= r_s1[a];
                r_sv[0][a] <= r_s2[a];
            end
            r_l2[0] <= L2_W'(r_sq[0]) + L2_W'(r_sq[1]) + L2_W'(r_sq[2]);
            r_rm[0] <= '0;
            r_rt[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < RT_W; k++) begin : g_root
        logic [RM_W-1:0] w_rem;
        logic [RM_W-1:0] w_trial;
        logic            w_ge;
        always_comb begin
            w_rem   = {r_rm[k][RM_W-3:0], r_l2[k][2*(RT_W-1-k)+1 -: 2]};
            w_trial = RM_W'({r_rt[k], 2'b01});
            w_ge    = (w_rem >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rm[k+1] <= w_ge ? (w_rem - w_trial) : w_rem;
                r_rt[k+1] <= {r_rt[k][RT_W-2:0], w_ge};
                r_l2[k+1] <= r_l2[k];
                for (int a = 0; a < 3; a++) begin
                    r_sv[k+1][a] <= r_sv[k][a];
                end
            end
        end
    end

    // divider setup: dividend 2*|s|*2^frac + len over 2*len
    logic [S_W-1:0]   w_mag [3];
    logic [NUM_W-1:0] w_num [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = r_sv[RT_W][a][S_W-1] ? S_W'(-r_sv[RT_W][a]) : r_sv[RT_W][a];
            w_num[a] = NUM_W'({w_mag[a], {Q_W{1'b0}}}) + NUM_W'(r_rt[RT_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_dr[0][a] <= w_num[a][NUM_W-1:Q_W];
                r_dq[0][a] <= w_num[a][Q_W-1:0];
                r_sg[0][a] <= r_sv[RT_W][a][S_W-1];
            end
            r_dn[0] <= {r_rt[RT_W], 1'b0};
            r_zr[0] <= (r_rt[RT_W] == '0);
        end
    end

    // restoring divide, one quotient bit per stage, quotient shifts into the low bits
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [D_W:0] w_t  [3];
        logic         w_ge [3];
        always_comb begin
            for (int a = 0; a < 3; a++) begin
                w_t[a]  = {r_dr[j][a], r_dq[j][a][Q_W-1]};
                w_ge[a] = (w_t[a] >= {1'b0, r_dn[j]});
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                for (int a = 0; a < 3; a++) begin
                    r_dr[j+1][a] <= w_ge[a] ? D_W'(w_t[a] - {1'b0, r_dn[j]})
                                            : w_t[a][D_W-1:0];
                    r_dq[j+1][a] <= {r_dq[j][a][Q_W-2:0], w_ge[a]};
                    r_sg[j+1][a] <= r_sg[j][a];
                end
                r_dn[j+1] <= r_dn[j];
                r_zr[j+1] <= r_zr[j];
            end
        end
    end

    // saturate, restore sign, zero-length midpoint gives the origin
    logic [Q_W-1:0] w_sat [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sat[a] = (r_dq[Q_W][a] > Q_W'(MAG_LIM)) ? Q_W'(MAG_LIM) : r_dq[Q_W][a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                if (r_zr[Q_W]) begin
                    r_m[a] <= '0;
                end else if (r_sg[Q_W][a]) begin
                    r_m[a] <= C_W'(-C_W'(w_sat[a]));
                end else begin
                    r_m[a] <= C_W'(w_sat[a]);
                end
            end
        end
    end

    assign o_m = r_m;

endmodule

// ===== rtl/core/ics_merge.sv =====
// holds one finished triangle and its midpoints, sends the four children
module ics_merge import ics_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_vec       i_v0,
    input  t_vec       i_v1,
    input  t_vec       i_v2,
    input  t_vec       i_ab,
    input  t_vec       i_bc,
    input  t_vec       i_ca,
    output logic       o_take,
    ics_out_if.source  o_tri
);

    logic       r_busy;
    logic [1:0] r_slot;
    t_vec       r_v0, r_v1, r_v2, r_ab, r_bc, r_ca;
    t_vec       w_a, w_b, w_c;
    logic       w_done;

    assign w_done = r_busy && o_tri.ready && (r_slot == SLOT_CTR);
    assign o_take = i_vld && (!r_busy || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SLOT_FIRST;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_slot <= SLOT_FIRST;
        end else if (r_busy && o_tri.ready) begin
            if (r_slot == SLOT_CTR) begin
                r_busy <= 1'b0;
            end else begin
                r_slot <= r_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_v0 <= i_v0;
            r_v1 <= i_v1;
            r_v2 <= i_v2;
            r_ab <= i_ab;
            r_bc <= i_bc;
            r_ca <= i_ca;
        end
    end

    always_comb begin
        case (r_slot)
            SLOT_FIRST: begin
                w_a = r_v0; w_b = r_ab; w_c = r_ca;
            end
            SLOT_SECOND: begin
                w_a = r_v1; w_b = r_bc; w_c = r_ab;
            end
            SLOT_THIRD: begin
                w_a = r_v2; w_b = r_ca; w_c = r_bc;
            end
            default: begin
                w_a = r_ab; w_b = r_bc; w_c = r_ca;
            end
        endcase
    end

    assign o_tri.valid         = r_busy;
    assign o_tri.data.out_a_x  = w_a[0];
    assign o_tri.data.out_a_y  = w_a[1];
    assign o_tri.data.out_a_z  = w_a[2];
    assign o_tri.data.out_b_x  = w_b[0];
    assign o_tri.data.out_b_y  = w_b[1];
    assign o_tri.data.out_b_z  = w_b[2];
    assign o_tri.data.out_c_x  = w_c[0];
    assign o_tri.data.out_c_y  = w_c[1];
    assign o_tri.data.out_c_z  = w_c[2];
    assign o_tri.data.sub_slot = r_slot;
    assign o_tri.data.is_last  = (r_slot == SLOT_CTR);

endmodule

// ===== tb/icosphere_triangle_subdivider_tb.sv =====
// testbench for the icosphere subdivider: random and directed triangles, checked child by child
`timescale 1ns / 1ps

module icosphere_triangle_subdivider_tb import ics_pkg::*;;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_RANDOM    = 430;
    localparam int DRAIN_WAIT  = LAT + 20;

    class child_board;
        t_tri_out children_due[$];
        int       mismatches;

        function automatic longint unsigned isqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // midpoint pushed back onto the unit sphere, rounded, saturated
        function automatic t_vec sphere_mid(t_vec p, t_vec q);
            longint          s[3];
            longint unsigned l2, len, mag, quo;
            t_vec            m;
            l2 = 0;
            for (int i = 0; i < 3; i++) begin
                s[i] = longint'($signed(p[i])) + longint'($signed(q[i]));
                l2 += longint'(s[i] * s[i]);
            end
            len = isqrt(l2);
            for (int i = 0; i < 3; i++) begin
                if (len == 0) begin
                    m[i] = '0;
                end else begin
                    mag = (s[i] < 0) ? -s[i] : s[i];
                    quo = (2 * (mag << FRAC_BITS) + len) / (2 * len);
                    if (quo > MAG_LIM) quo = MAG_LIM;
                    m[i] = (s[i] < 0) ? C_W'(-longint'(quo)) : C_W'(quo);
                end
            end
            return m;
        endfunction

        function automatic t_tri_out child(t_vec a, t_vec b, t_vec c, logic [1:0] slot);
            t_tri_out o;
            o.out_a_x = a[0]; o.out_a_y = a[1]; o.out_a_z = a[2];
            o.out_b_x = b[0]; o.out_b_y = b[1]; o.out_b_z = b[2];
            o.out_c_x = c[0]; o.out_c_y = c[1]; o.out_c_z = c[2];
            o.sub_slot = slot;
            o.is_last  = (slot == SLOT_CTR);
            return o;
        endfunction

        function void add_due(t_tri_out c);
            children_due.insert(children_due.size(), c);
        endfunction

        function void note_tri(t_tri_in t);
            t_vec v0, v1, v2, ab, bc, ca;
            v0 = {t.first_z, t.first_y, t.first_x};
            v1 = {t.second_z, t.second_y, t.second_x};
            v2 = {t.third_z, t.third_y, t.third_x};
            ab = sphere_mid(v0, v1);
            bc = sphere_mid(v1, v2);
            ca = sphere_mid(v2, v0);
            add_due(child(v0, ab, ca, SLOT_FIRST));
            add_due(child(v1, bc, ab, SLOT_SECOND));
            add_due(child(v2, ca, bc, SLOT_THIRD));
            add_due(child(ab, bc, ca, SLOT_CTR));
        endfunction

        function void check_child(t_tri_out got);
            t_tri_out want;
            bit       bad;
            if (children_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected child item: %p", got);
                return;
            end
            want = children_due.pop_front();
            bad = (got.out_a_x !== want.out_a_x) || (got.out_a_y !== want.out_a_y) ||
                  (got.out_a_z !== want.out_a_z) || (got.out_b_x !== want.out_b_x) ||
                  (got.out_b_y !== want.out_b_y) || (got.out_b_z !== want.out_b_z) ||
                  (got.out_c_x !== want.out_c_x) || (got.out_c_y !== want.out_c_y) ||
                  (got.out_c_z !== want.out_c_z) || (got.sub_slot !== want.sub_slot) ||
                  (got.is_last !== want.is_last);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("child mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ics_in_if  tri_in ();
    ics_out_if tri_out ();

    icosphere_triangle_subdivider dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_in.sink),
        .o_tri  (tri_out.source)
    );

    child_board board;
    bit         calm;
    bit         hold_req;
    int         hold_left;
    int         cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        tri_in.valid = 1'b0;
        tri_in.data = '0;
        tri_out.ready = 1'b0;
        board = new();
        calm = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        cycles = 0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            tri_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            tri_out.ready <= 1'b0;
        end else begin
            tri_out.ready <= calm || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tri_out.valid && tri_out.ready) board.check_child(tri_out.data);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** icosphere_triangle_subdivider: FAILED **");
            $finish;
        end
    end

    task automatic send_tri(t_tri_in t);
        while (!calm && $urandom_range(99) < 29) begin
            tri_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_in.valid <= 1'b1;
        tri_in.data  <= t;
        @(posedge i_clk);
        while (!tri_in.ready) @(posedge i_clk);
        board.note_tri(t);
    endtask

    task automatic drain();
        while (board.children_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_tri_in make_tri(logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        t_tri_in t;
        t.first_x = ax;  t.first_y = ay;  t.first_z = az;
        t.second_x = bx; t.second_y = by; t.second_z = bz;
        t.third_x = cx;  t.third_y = cy;  t.third_z = cz;
        return t;
    endfunction

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom_range(32768)) - 16'd16384;
            1: return 16'($urandom);
            default: begin
                case ($urandom_range(3))
                    0: return 16'd16384;
                    1: return -16'sd16384;
                    2: return 16'd0;
                    default: return 16'($urandom_range(32768)) - 16'd16384;
                endcase
            end
        endcase
    endfunction

    function automatic t_tri_in rand_tri();
        int      mode;
        t_tri_in t;
        mode = $urandom_range(9);
        mode = (mode < 6) ? 0 : (mode < 8) ? 2 : 1;
        t = make_tri(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), rand_coord(mode), rand_coord(mode));
        // opposite corners now and then, for a zero-length midpoint sum
        if ($urandom_range(19) == 0) begin
            t.second_x = -t.first_x; t.second_y = -t.first_y; t.second_z = -t.first_z;
        end
        return t;
    endfunction

    initial begin
        localparam logic [15:0] P1 = 16'd16384;
        localparam logic [15:0] N1 = -16'sd16384;
        localparam logic [15:0] H  = 16'd11585;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: axis corners, zero edges, extremes of the coordinate range
        send_tri(make_tri(P1, 0, 0, 0, P1, 0, 0, 0, P1));
        send_tri(make_tri(N1, 0, 0, 0, N1, 0, 0, 0, N1));
        send_tri(make_tri(P1, 0, 0, N1, 0, 0, 0, P1, 0));
        send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(make_tri(0, 0, 0, P1, 0, 0, 0, 0, N1));
        send_tri(make_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h8000, 16'h8000, 16'h8000));
        send_tri(make_tri(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h7fff, 16'h8000, 16'h0001));
        send_tri(make_tri(16'h8000, 0, 0, 16'h7fff, 0, 0, 16'h8000, 16'h7fff, 0));
        send_tri(make_tri(H, H, 0, 0, H, H, H, 0, H));
        send_tri(make_tri(-H, H, 0, 0, -H, H, H, 0, -H));
        send_tri(make_tri(16'hffff, 0, 0, 16'h0001, 0, 0, 0, 16'hffff, 0));
        send_tri(make_tri(16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001));
        send_tri(make_tri(16'hffff, 16'hffff, 16'hffff, 16'h5555, 16'haaaa, 16'h5555,
                          16'haaaa, 16'h5555, 16'haaaa));
        send_tri(make_tri(P1, P1, P1, P1, P1, P1, N1, N1, N1));
        for (int i = 0; i < 6; i++) send_tri(rand_tri());

        // sender waits for every child, then random traffic
        tri_in.valid <= 1'b0;
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) hold_req = 1'b1;
            if (i == 200) calm = 1'b1;
            if (i == 260) calm = 1'b0;
            if (i == 330) begin
                tri_in.valid <= 1'b0;
                drain();
                @(posedge i_clk);
            end
            send_tri(rand_tri());
        end
        tri_in.valid <= 1'b0;

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.mismatches == 0 && board.children_due.size() == 0) begin
            $display("** icosphere_triangle_subdivider: PASSED **");
        end else begin
            $display("** icosphere_triangle_subdivider: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ics_pkg.sv
rtl/core/ics_if.sv
rtl/core/ics_lane.sv
rtl/core/ics_merge.sv
rtl/core/icosphere_triangle_subdivider.sv
tb/icosphere_triangle_subdivider_tb.sv
